### hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

    // operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_BLANK    = 8'h20;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;

    // attribute after reset
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_need;
        logic sweep_done;
    } dp_status_t;

endpackage

### hw/rtl/text_console_char_writer_unit.sv
`timescale 1ns / 1ps

// channel  | signals                                   | handshake
// ---------+-------------------------------------------+--------------------------
// command  | op, char_code, cell_index                 | taken when start && !busy
// result   | cursor_location, cursor_column,           | valid one cycle on done
//          | cursor_row, scrolled, cell_data           |
// config   | cfg_data                                  | written when cfg_we
//
// put, read and unused ops pass through one execute state on the cell store,
// then the done beat, in which the next command can be taken
// clear and scrolling puts add a sweep over all COLUMNS*ROWS cells, one cell read
// and one cell written per cycle
// after reset the same sweep blanks the store with busy high; config writes are taken
// the receiver cannot stall: each result is shown for one cycle only

module text_console_char_writer_unit
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [10:0] cursor_location,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic        scrolled,
    output logic [15:0] cell_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    tccw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // cursor and cell store
    tccw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .op              (op),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .status          (status),
        .cursor_location (cursor_location),
        .cursor_column   (cursor_column),
        .cursor_row      (cursor_row),
        .scrolled        (scrolled),
        .cell_data       (cell_data)
    );

    // a result beat leaves the block ready for the next command
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy high during result beat");

    // an accepted command always occupies the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accept");

    // result beats are never adjacent
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    // a scroll always leaves the cursor at the left edge
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_column == 7'd0))
        else $error("scroll with nonzero column");

endmodule

### hw/rtl/tccw_ctrl.sv
`timescale 1ns / 1ps

module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                if (status.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.sweep_need)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_SWEEP:
            begin
                if (status.sweep_done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= done_next;
        end
    end

    // datapath commands
    always_comb
    begin
        cmd.load  = (state_reg == S_IDLE) && start;
        cmd.exec  = (state_reg == S_EXEC);
        cmd.sweep = (state_reg == S_SWEEP) || (state_reg == S_INIT);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### hw/rtl/tccw_datapath.sv
`timescale 1ns / 1ps

module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output dp_status_t  status,
    output logic [10:0] cursor_location,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic        scrolled,
    output logic [15:0] cell_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
    localparam int AW = $clog2(CELL_COUNT);
    localparam int SW = $clog2(CELL_COUNT + 1);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int TW = $clog2(TAB_STOP);
    localparam int NW = $clog2(COLUMNS + TAB_STOP + 1);

    // cell store
    logic [15:0] mem [CELL_COUNT];
    logic [15:0] rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic [AW-1:0] mem_ra;

    // latched beat and settings
    logic [1:0]  op_reg;
    logic [7:0]  char_reg;
    logic [10:0] index_reg;
    logic [7:0]  attr_reg;

    // cursor and tab phase
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [TW-1:0] phase_reg;
    logic [TW-1:0] phase_next;
    logic          scrolled_reg;
    logic          scroll_next;
    logic          read_hit_reg;

    // sweep control
    logic [SW-1:0] sweep_reg;
    logic          sweep_copy_reg;
    logic          sweep_init_reg;

    logic [NW-1:0] ncol;
    logic          row_inc;
    logic          put_write;
    logic [31:0]   cur_addr32;
    logic [31:0]   index32;
    logic [31:0]   sweep_rd32;
    logic [31:0]   sweep_wr32;
    logic [31:0]   col32;
    logic [31:0]   row32;
    logic [7:0]    blank_attr;

    assign cur_addr32 = 32'(row_reg) * COLUMNS + 32'(col_reg);
    assign index32    = 32'(index_reg);
    assign sweep_rd32 = 32'(sweep_reg) + COLUMNS;
    assign sweep_wr32 = 32'(sweep_reg) - 32'd1;
    assign blank_attr = sweep_init_reg ? RESET_ATTR : attr_reg;

    // cursor update for a put or a clear
    always_comb
    begin
        ncol        = NW'(col_reg);
        phase_next  = phase_reg;
        row_inc     = 1'b0;
        put_write   = 1'b0;
        col_next    = col_reg;
        row_next    = row_reg;
        scroll_next = 1'b0;
        if (op_reg == OP_PUT)
        begin
            case (char_reg)
                CHAR_BS:
                begin
                    if (col_reg != '0)
                    begin
                        ncol       = NW'(col_reg) - NW'(1);
                        phase_next = (phase_reg == '0) ? TW'(TAB_STOP - 1)
                                                       : phase_reg - TW'(1);
                    end
                end
                CHAR_TAB:
                begin
                    ncol       = NW'(col_reg) - NW'(phase_reg) + NW'(TAB_STOP);
                    phase_next = '0;
                end
                CHAR_CR:
                begin
                    ncol       = '0;
                    phase_next = '0;
                end
                CHAR_LF:
                begin
                    ncol       = '0;
                    phase_next = '0;
                    row_inc    = 1'b1;
                end
                default:
                begin
                    if (char_reg inside {[CHAR_PRINT_LO:CHAR_PRINT_HI]})
                    begin
                        put_write  = 1'b1;
                        ncol       = NW'(col_reg) + NW'(1);
                        phase_next = (phase_reg == TW'(TAB_STOP - 1)) ? '0
                                                                      : phase_reg + TW'(1);
                    end
                end
            endcase
            // wrap past the last column
            if (ncol >= NW'(COLUMNS))
            begin
                ncol       = '0;
                phase_next = '0;
                row_inc    = 1'b1;
            end
            col_next = CW'(ncol);
            if (row_inc)
            begin
                if (row_reg == RW'(ROWS - 1))
                begin
                    scroll_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
        end
        else if (op_reg == OP_CLEAR)
        begin
            col_next   = '0;
            row_next   = '0;
            phase_next = '0;
        end
    end

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cur_addr32[AW-1:0];
        mem_wd = {attr_reg, char_reg};
        mem_ra = (index32 < CELL_COUNT) ? index32[AW-1:0] : '0;
        if (cmd.exec)
        begin
            mem_we = put_write;
        end
        else if (cmd.sweep)
        begin
            if (sweep_copy_reg && (32'(sweep_reg) < COPY_COUNT))
            begin
                mem_ra = sweep_rd32[AW-1:0];
            end
            mem_we = (sweep_reg != '0);
            mem_wa = sweep_wr32[AW-1:0];
            mem_wd = (sweep_copy_reg && (sweep_wr32 < COPY_COUNT)) ? rd_reg
                                                                   : {blank_attr, CHAR_BLANK};
        end
    end

    // cell store ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[mem_ra];
    end

    // beat capture and attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            char_reg  <= char_code;
            index_reg <= cell_index;
        end
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end
        else if (cmd.exec)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    // result flags
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            scrolled_reg <= scroll_next;
            read_hit_reg <= (op_reg == OP_READ) && (index32 < CELL_COUNT);
        end
    end

    // sweep counter and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= '0;
            sweep_copy_reg <= 1'b0;
            sweep_init_reg <= 1'b1;
        end
        else if (cmd.exec)
        begin
            sweep_reg      <= '0;
            sweep_copy_reg <= scroll_next;
            sweep_init_reg <= 1'b0;
        end
        else if (cmd.sweep)
        begin
            if (status.sweep_done)
            begin
                sweep_reg <= '0;
            end
            else
            begin
                sweep_reg <= sweep_reg + SW'(1);
            end
        end
    end

    assign status.sweep_need = scroll_next || (op_reg == OP_CLEAR);
    assign status.sweep_done = (sweep_reg == SW'(CELL_COUNT));

    // result fields
    assign col32           = 32'(col_reg);
    assign row32           = 32'(row_reg);
    assign cursor_location = cur_addr32[10:0];
    assign cursor_column   = col32[6:0];
    assign cursor_row      = row32[4:0];
    assign scrolled        = scrolled_reg;
    assign cell_data       = read_hit_reg ? rd_reg : 16'h0000;

endmodule
